/* sv/edd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Error diffusion dither package
// Register map, configuration widths and reset values, and the flag group
// that travels with each request from the front to the back.
// ----------------------------------------------------------------------------
package edd_pkg;

  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;

  localparam int IMAGE_WIDTH_BITS = 13;
  localparam int IMAGE_HEIGHT_BITS = 16;
  localparam int LEVEL_BITS = 8;
  localparam int THRESHOLD_BITS = 12;

  localparam logic [IMAGE_WIDTH_BITS-1:0] IMAGE_WIDTH_RESET = 13'd4096;
  localparam logic [IMAGE_HEIGHT_BITS-1:0] IMAGE_HEIGHT_RESET = 16'd1;
  localparam logic [LEVEL_BITS-1:0] LOW_LEVEL_RESET = 8'd0;
  localparam logic [LEVEL_BITS-1:0] HIGH_LEVEL_RESET = 8'd255;
  localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 12'd2040;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_LOW_LEVEL    = 3'd2,
    REG_HIGH_LEVEL   = 3'd3,
    REG_THRESHOLD    = 3'd4
  } edd_reg_t;

  typedef struct packed {
    logic first_row;
    logic last_col;
    logic frame_end;
  } edd_flags_t;

endpackage

/* sv/edd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Error diffusion dither front
// Accepts samples, tracks the raster position and tags each request with
// its column and its row and frame flags.
// ----------------------------------------------------------------------------
module edd_front import edd_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int SAMPLE_BITS = 8,
  localparam int COL_BITS = $clog2(MAX_WIDTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [SAMPLE_BITS-1:0]       sample,
  input  logic [IMAGE_WIDTH_BITS-1:0]  image_width,
  input  logic [IMAGE_HEIGHT_BITS-1:0] image_height,
  output logic                         push,
  input  logic                         queue_ready,
  output edd_flags_t                   flags,
  output logic [COL_BITS-1:0]          col_out,
  output logic [SAMPLE_BITS-1:0]       sample_out
);

  logic [COL_BITS-1:0]          column_count, column_count_next;
  logic [IMAGE_HEIGHT_BITS-1:0] row_count, row_count_next;
  logic [31:0]                  width_eff, height_eff;
  logic                         last_row;

  always_comb begin
    width_eff = 32'(image_width);
    if (image_width == '0) begin
      width_eff = 32'd1;
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      width_eff = 32'(MAX_WIDTH);
    end
    height_eff = 32'(image_height);
    if (image_height == '0) begin
      height_eff = 32'd1;
    end

    flags.last_col = (32'(column_count) + 32'd1) >= width_eff;
    last_row = (32'(row_count) + 32'd1) >= height_eff;
    flags.first_row = (row_count == '0);
    flags.frame_end = flags.last_col && last_row;

    column_count_next = flags.last_col ? '0 : column_count + 1'b1;
    row_count_next = row_count;
    if (flags.last_col) begin
      row_count_next = last_row ? '0 : row_count + 1'b1;
    end

    s_tready = queue_ready;
    push = s_tvalid && queue_ready;
    col_out = column_count;
    sample_out = sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
    end else if (push) begin
      column_count <= column_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

/* sv/edd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Error diffusion dither queue
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module edd_queue #(
  parameter int WIDTH = 8,
  parameter int ADDR_BITS = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int DEPTH = 2 ** ADDR_BITS;

  logic [WIDTH-1:0]     entries [DEPTH];
  logic [ADDR_BITS-1:0] wr_ptr, rd_ptr;
  logic [ADDR_BITS:0]   count, count_next;
  logic                 do_push, do_pop;

  always_comb begin
    in_ready = (count != (ADDR_BITS + 1)'(DEPTH));
    out_valid = (count != '0);
    out_data = entries[rd_ptr];
    do_push = in_valid && in_ready;
    do_pop = out_valid && out_ready;
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= in_data;
    end
  end

endmodule

/* sv/edd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Error diffusion dither back
// Reads the line store, forms the corrected value, picks the level, spreads
// the quantization error and registers the result.
// ----------------------------------------------------------------------------
module edd_back import edd_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int SAMPLE_BITS = 8,
  parameter int ERROR_BITS = 16,
  localparam int COL_BITS = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  edd_flags_t                in_flags,
  input  logic [COL_BITS-1:0]       in_col,
  input  logic [SAMPLE_BITS-1:0]    in_sample,
  input  logic [LEVEL_BITS-1:0]     low_level,
  input  logic [LEVEL_BITS-1:0]     high_level,
  input  logic [THRESHOLD_BITS-1:0] threshold,
  output logic                      m_valid,
  input  logic                      m_ready,
  output logic [LEVEL_BITS-1:0]     dithered,
  output logic                      bounds_error,
  output logic                      frame_end
);

  localparam int XW = ((ERROR_BITS + 3 > SAMPLE_BITS + 5) ? ERROR_BITS + 3 : SAMPLE_BITS + 5)
                      + 2;
  localparam logic signed [XW-1:0] EMAX = XW'((64'sd1 <<< (ERROR_BITS - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] EMIN = ~EMAX;

  function automatic logic signed [ERROR_BITS-1:0] sat(input logic signed [XW-1:0] x);
    if (x > EMAX) begin
      return EMAX[ERROR_BITS-1:0];
    end else if (x < EMIN) begin
      return EMIN[ERROR_BITS-1:0];
    end
    return x[ERROR_BITS-1:0];
  endfunction

  logic signed [ERROR_BITS-1:0] line_store [MAX_WIDTH];

  logic                         b_valid;
  edd_flags_t                   b_flags;
  logic [COL_BITS-1:0]          b_col;
  logic [SAMPLE_BITS-1:0]       b_sample;
  logic signed [ERROR_BITS-1:0] rd_data;
  logic                         fw_a_valid, fw_p_valid;
  logic [COL_BITS-1:0]          fw_a_addr, fw_p_addr;
  logic signed [ERROR_BITS-1:0] fw_a_data, fw_p_data;

  logic                         pend_valid, pend_valid_next;
  logic [COL_BITS-1:0]          pend_addr, pend_addr_next;
  logic signed [ERROR_BITS-1:0] pend_data, pend_data_next;

  logic signed [ERROR_BITS-1:0] right_carry, below_left_partial, below_partial;

  logic                         fire, load;
  logic signed [ERROR_BITS-1:0] line_val, incoming, corrected, q, wa_data, blp_new;
  logic signed [XW-1:0]         sample_x, corrected_x, threshold_x, level_x, qx;
  logic signed [XW-1:0]         s1, s3, s5, s7;
  logic [LEVEL_BITS-1:0]        level;
  logic                         wa_en, wr_en;
  logic [COL_BITS-1:0]          wa_addr, wr_addr;
  logic signed [ERROR_BITS-1:0] wr_data;

  always_comb begin
    fire = b_valid && (!m_valid || m_ready);
    in_ready = !b_valid || fire;
    load = in_valid && in_ready;

    if (fw_p_valid && fw_p_addr == b_col) begin
      line_val = fw_p_data;
    end else if (fw_a_valid && fw_a_addr == b_col) begin
      line_val = fw_a_data;
    end else begin
      line_val = rd_data;
    end

    if (b_flags.first_row) begin
      incoming = right_carry;
    end else begin
      incoming = sat(XW'(right_carry) + XW'(line_val));
    end

    sample_x = signed'(XW'({b_sample, 4'b0000}));
    corrected = sat(sample_x + XW'(incoming));
    corrected_x = XW'(corrected);
    threshold_x = signed'(XW'(threshold));
    level = (corrected_x >= threshold_x) ? high_level : low_level;
    level_x = signed'(XW'({level, 4'b0000}));
    q = sat(corrected_x - level_x);

    qx = XW'(q);
    s1 = qx >>> 4;
    s3 = (qx + (qx <<< 1)) >>> 4;
    s5 = (qx + (qx <<< 2)) >>> 4;
    s7 = ((qx <<< 3) - qx) >>> 4;

    wa_data = sat(XW'(below_left_partial) + s3);
    blp_new = sat(XW'(below_partial) + s5);
    wa_en = fire && (b_col != '0);
    wa_addr = b_col - 1'b1;

    wr_en = wa_en || pend_valid;
    wr_addr = wa_en ? wa_addr : pend_addr;
    wr_data = wa_en ? wa_data : pend_data;

    pend_valid_next = pend_valid && wa_en;
    pend_addr_next = pend_addr;
    pend_data_next = pend_data;
    if (fire && b_flags.last_col) begin
      pend_valid_next = 1'b1;
      pend_addr_next = b_col;
      pend_data_next = blp_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      pend_valid <= 1'b0;
      m_valid <= 1'b0;
      right_carry <= '0;
      below_left_partial <= '0;
      below_partial <= '0;
    end else begin
      pend_valid <= pend_valid_next;
      if (load) begin
        b_valid <= 1'b1;
      end else if (fire) begin
        b_valid <= 1'b0;
      end
      if (fire) begin
        m_valid <= 1'b1;
        if (b_flags.last_col) begin
          right_carry <= '0;
          below_left_partial <= '0;
          below_partial <= '0;
        end else begin
          right_carry <= s7[ERROR_BITS-1:0];
          below_left_partial <= blp_new;
          below_partial <= s1[ERROR_BITS-1:0];
        end
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    pend_data <= pend_data_next;
    if (load) begin
      b_flags <= in_flags;
      b_col <= in_col;
      b_sample <= in_sample;
      fw_a_valid <= wr_en;
      fw_a_addr <= wr_addr;
      fw_a_data <= wr_data;
      fw_p_valid <= pend_valid_next;
      fw_p_addr <= pend_addr_next;
      fw_p_data <= pend_data_next;
    end
    if (fire) begin
      dithered <= level;
      bounds_error <= (high_level < low_level);
      frame_end <= b_flags.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store[wr_addr] <= wr_data;
    end
    if (load) begin
      rd_data <= line_store[in_col];
    end
  end

endmodule

/* sv/error_diffusion_dither.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Error diffusion dither
// Floyd-Steinberg dither of one raster channel to two output levels.
//
//   Channel  Direction  Carries
//   s_*      in         sample (s_tdata)
//   m_*      out        dithered (m_tdata), bounds_error (m_tuser),
//                       frame_end (m_tlast)
//   APB      in/out     configuration registers at byte address 4*index
//
// One request is accepted per clock while m_tready stays high; its result
// passes the queue, the back stage input registers and the output register.
// The rate is set by the error carry loop in the back stage, one pixel a clock.
// Reset clears the raster counters, the carries and the queue; the line
// store is not cleared, since the first row of a frame never reads it.
// When m_tready is low the two-entry queue fills and then s_tready falls.
// ----------------------------------------------------------------------------
module error_diffusion_dither import edd_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int SAMPLE_BITS = 8,
  parameter int ERROR_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // Fields from bit 0: sample.
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // Fields from bit 0: dithered.
  output logic [7:0]                            m_tdata,
  // Fields from bit 0: bounds_error.
  output logic [0:0]                            m_tuser,
  output logic                                  m_tlast,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [APB_ADDR_BITS-1:0]              paddr,
  input  logic [APB_DATA_BITS-1:0]              pwdata,
  output logic [APB_DATA_BITS-1:0]              prdata,
  output logic                                  pready
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int QW = $bits(edd_flags_t) + COL_BITS + SAMPLE_BITS;

  logic [IMAGE_WIDTH_BITS-1:0]  image_width;
  logic [IMAGE_HEIGHT_BITS-1:0] image_height;
  logic [LEVEL_BITS-1:0]        low_level, high_level;
  logic [THRESHOLD_BITS-1:0]    threshold;
  logic                         cfg_write;

  logic                   push, queue_ready, q_valid, q_ready;
  edd_flags_t             f_flags, q_flags;
  logic [COL_BITS-1:0]    f_col, q_col;
  logic [SAMPLE_BITS-1:0] f_sample, q_sample;
  logic [QW-1:0]          q_out;
  logic                   bounds_error;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (edd_reg_t'(paddr[4:2]))
      REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(image_height);
      REG_LOW_LEVEL:    prdata = APB_DATA_BITS'(low_level);
      REG_HIGH_LEVEL:   prdata = APB_DATA_BITS'(high_level);
      REG_THRESHOLD:    prdata = APB_DATA_BITS'(threshold);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
      low_level <= LOW_LEVEL_RESET;
      high_level <= HIGH_LEVEL_RESET;
      threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (edd_reg_t'(paddr[4:2]))
        REG_IMAGE_WIDTH:  image_width <= pwdata[IMAGE_WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[IMAGE_HEIGHT_BITS-1:0];
        REG_LOW_LEVEL:    low_level <= pwdata[LEVEL_BITS-1:0];
        REG_HIGH_LEVEL:   high_level <= pwdata[LEVEL_BITS-1:0];
        REG_THRESHOLD:    threshold <= pwdata[THRESHOLD_BITS-1:0];
        default:          ;
      endcase
    end
  end

  edd_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .sample       (s_tdata[SAMPLE_BITS-1:0]),
    .image_width  (image_width),
    .image_height (image_height),
    .push         (push),
    .queue_ready  (queue_ready),
    .flags        (f_flags),
    .col_out      (f_col),
    .sample_out   (f_sample)
  );

  edd_queue #(
    .WIDTH     (QW),
    .ADDR_BITS (1)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_ready  (queue_ready),
    .in_data   ({f_flags, f_col, f_sample}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_out)
  );

  assign {q_flags, q_col, q_sample} = q_out;

  edd_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ERROR_BITS  (ERROR_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_ready     (q_ready),
    .in_flags     (q_flags),
    .in_col       (q_col),
    .in_sample    (q_sample),
    .low_level    (low_level),
    .high_level   (high_level),
    .threshold    (threshold),
    .m_valid      (m_tvalid),
    .m_ready      (m_tready),
    .dithered     (m_tdata),
    .bounds_error (bounds_error),
    .frame_end    (m_tlast)
  );

  assign m_tuser = bounds_error;

endmodule

/* sv/edd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Error diffusion dither checker
// Port-level checks on result hold, occupancy, reset and register readback.
// ----------------------------------------------------------------------------
module edd_checker import edd_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [7:0]               m_tdata,
  input logic [0:0]               m_tuser,
  input logic                     m_tlast,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic                     pready,
  input logic [APB_ADDR_BITS-1:0] paddr,
  input logic [APB_DATA_BITS-1:0] pwdata,
  input logic [APB_DATA_BITS-1:0] prdata
);

  logic [3:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 4'(s_tvalid && s_tready) - 4'(m_tvalid && m_tready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> outstanding != 4'd0)
    else $error("result without an accepted request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 4'd4)
    else $error("more requests in flight than storage allows");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[4:2] == REG_LOW_LEVEL)
      ##1 (paddr[4:2] == REG_LOW_LEVEL) |-> prdata[7:0] == $past(pwdata[7:0]))
    else $error("register readback mismatch");

endmodule

bind error_diffusion_dither edd_checker u_edd_checker (.*);
